// ----- hdl/lcwc_pkg.sv -----
`timescale 1ns / 1ps
// lcwc_pkg: shared types, constants and helpers for the load-cell weigh unit
// no dependencies

package lcwc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int AVG_COUNT   = 3;

    // sum of up to four samples plus sign
    localparam int SUM_W       = SAMPLE_BITS + 2;
    localparam int BIT_CNT_W   = 5;
    localparam int RDG_CNT_W   = 2;
    localparam int CPG_W       = 16;
    localparam int TIMEOUT_W   = 24;
    localparam int GRAMS_W     = 16;
    localparam int CLASS_W     = 3;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_STEP_W  = $clog2(SUM_W);

    localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(SAMPLE_BITS - 1);
    localparam logic [RDG_CNT_W-1:0] NEED_WEIGH = RDG_CNT_W'(AVG_COUNT);
    localparam logic [RDG_CNT_W-1:0] NEED_TARE  = RDG_CNT_W'(1);
    localparam logic [DIV_STEP_W-1:0] DIV_LAST  = DIV_STEP_W'(SUM_W - 1);
    localparam logic [CPG_W-1:0] AVG_DIVISOR    = CPG_W'(AVG_COUNT);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WEIGH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TARE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd2;

    // configuration reset values
    localparam logic [CPG_W-1:0]     CPG_RESET     = 16'd2280;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [GRAMS_W-1:0]   MAX_RESET     = 16'd500;

    // weight classes
    localparam logic [CLASS_W-1:0] CLS_FALSE   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_MOUSE   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_RAT     = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_INSECT  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd4;

    localparam logic [GRAMS_W-1:0] G_FALSE_LIM = 16'd5;
    localparam logic [GRAMS_W-1:0] G_MOUSE_LO  = 16'd15;
    localparam logic [GRAMS_W-1:0] G_MOUSE_HI  = 16'd30;
    localparam logic [GRAMS_W-1:0] G_RAT_LO    = 16'd150;
    localparam logic [GRAMS_W-1:0] G_RAT_HI    = 16'd300;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             data_pin;
    } in_item_t;

    typedef struct packed {
        logic               clock_pin;
        logic               busy_res;
        logic               weigh_done;
        logic               tare_done;
        logic [GRAMS_W-1:0] weight_grams;
        logic [CLASS_W-1:0] weight_class;
        logic               ready_timed_out;
    } out_item_t;

    // converter link phase
    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_WAIT      = 6'b000010,
        PH_RISE      = 6'b000100,
        PH_SAMPLE    = 6'b001000,
        PH_PULSE     = 6'b010000,
        PH_PULSE_END = 6'b100000
    } phase_t;

    // item handling and divider sequencing
    typedef enum logic [4:0] {
        CTL_TICK = 5'b00001,
        CTL_DIV3 = 5'b00010,
        CTL_DIFF = 5'b00100,
        CTL_DIVC = 5'b01000,
        CTL_DONE = 5'b10000
    } ctl_t;

    function automatic logic [CLASS_W-1:0] classify_weight(input logic [GRAMS_W-1:0] g);
        logic [CLASS_W-1:0] cls;
        if (g < G_FALSE_LIM) begin
            cls = CLS_FALSE;
        end else if (g >= G_MOUSE_LO && g <= G_MOUSE_HI) begin
            cls = CLS_MOUSE;
        end else if (g >= G_RAT_LO && g <= G_RAT_HI) begin
            cls = CLS_RAT;
        end else if (g < G_MOUSE_LO) begin
            cls = CLS_INSECT;
        end else begin
            cls = CLS_UNKNOWN;
        end
        return cls;
    endfunction

endpackage

// ----- hdl/load_cell_weigh_and_classify_unit.sv -----
`timescale 1ns / 1ps
// load_cell_weigh_and_classify_unit: one item per converter half clock period; a tick
// that ends a weighing runs a bit-serial divider (one quotient bit per cycle) twice.
// Tick result registered the cycle after accept; weigh result via DIV3/DIFF/DIVC/DONE.
// Throughput: one item per cycle when the output is free; none while the divider runs.
// Reset: aresetn synchronous, active low; clears control state, tare and registers
// to their defaults. Depends on lcwc_pkg.

module load_cell_weigh_and_classify_unit
    import lcwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [CPG_W-1:0]     cpg_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [GRAMS_W-1:0]   max_grams_reg;

    // link state
    phase_t                 phase_reg, phase_next;
    logic                   is_tare_reg, is_tare_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [RDG_CNT_W-1:0]   rdg_cnt_reg, rdg_cnt_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] tare_reg, tare_next;
    logic [TIMEOUT_W-1:0]   wait_cnt_reg, wait_cnt_next;
    logic                   tout_seen_reg, tout_seen_next;

    // sequencing and divider
    ctl_t                  ctl_reg, ctl_next;
    logic [SUM_W-1:0]      dvd_reg, dvd_next;
    logic [CPG_W-1:0]      dvsr_reg, dvsr_next;
    logic [CPG_W-1:0]      rem_reg, rem_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic                  wtout_reg, wtout_next;

    // output slot
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic                 out_free;
    logic                 s_fire;
    logic                 complete;
    logic                 seq_done;
    logic                 weigh_start;
    logic [SUM_W-1:0]     reading;
    logic [TIMEOUT_W-1:0] wait_inc;
    logic [TIMEOUT_W-1:0] wait_lim;
    logic [RDG_CNT_W-1:0] need;
    out_item_t            tick_out;

    logic [CPG_W:0]       rem_sh;
    logic                 rem_ge;
    logic [SUM_W-1:0]     avg;
    logic [SUM_W-1:0]     diff;
    logic [GRAMS_W-1:0]   grams;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (ctl_reg == CTL_TICK) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    assign wait_inc = wait_cnt_reg + TIMEOUT_W'(1);
    assign wait_lim = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;

    // one tick of the converter link
    always_comb begin
        phase_next     = phase_reg;
        is_tare_next   = is_tare_reg;
        bit_cnt_next   = bit_cnt_reg;
        rdg_cnt_next   = rdg_cnt_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        tare_next      = tare_reg;
        wait_cnt_next  = wait_cnt_reg;
        tout_seen_next = tout_seen_reg;
        complete       = 1'b0;
        seq_done       = 1'b0;
        reading        = '0;
        need           = NEED_WEIGH;
        tick_out       = '0;
        tick_out.busy_res = 1'b1;

        unique case (phase_reg)
            PH_IDLE: begin
                tick_out.busy_res = 1'b0;
                if (s_item.command == CMD_WEIGH || s_item.command == CMD_TARE) begin
                    tick_out.busy_res = 1'b1;
                    is_tare_next   = (s_item.command == CMD_TARE);
                    rdg_cnt_next   = '0;
                    sum_next       = '0;
                    tout_seen_next = 1'b0;
                    wait_cnt_next  = '0;
                    phase_next     = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!s_item.data_pin) begin
                    tick_out.clock_pin = 1'b1;
                    bit_cnt_next = '0;
                    shift_next   = '0;
                    phase_next   = PH_SAMPLE;
                end else begin
                    wait_cnt_next = wait_inc;
                    if (wait_inc >= wait_lim) begin
                        tout_seen_next = 1'b1;
                        complete       = 1'b1;
                    end
                end
            end
            PH_RISE: begin
                tick_out.clock_pin = 1'b1;
                phase_next = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                shift_next   = {shift_reg[SAMPLE_BITS-2:0], s_item.data_pin};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                phase_next   = (bit_cnt_reg == BIT_LAST) ? PH_PULSE : PH_RISE;
            end
            PH_PULSE: begin
                tick_out.clock_pin = 1'b1;
                phase_next = PH_PULSE_END;
            end
            PH_PULSE_END: begin
                reading  = {{(SUM_W-SAMPLE_BITS){shift_reg[SAMPLE_BITS-1]}}, shift_reg};
                complete = 1'b1;
            end
            default: begin
                phase_next = PH_IDLE;
                tick_out.busy_res = 1'b0;
            end
        endcase

        if (complete) begin
            need          = is_tare_reg ? NEED_TARE : NEED_WEIGH;
            sum_next      = sum_reg + reading;
            rdg_cnt_next  = rdg_cnt_reg + RDG_CNT_W'(1);
            wait_cnt_next = '0;
            if (rdg_cnt_next >= need) begin
                seq_done          = 1'b1;
                tick_out.busy_res = 1'b0;
                tick_out.ready_timed_out = tout_seen_next;
                if (is_tare_reg) begin
                    tare_next          = reading[SAMPLE_BITS-1:0];
                    tick_out.tare_done = 1'b1;
                end
                phase_next = PH_IDLE;
            end else begin
                phase_next = PH_WAIT;
            end
        end
    end

    assign weigh_start = s_fire && seq_done && !is_tare_reg;

    // shared restoring divider step
    assign rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dvsr_reg};

    assign avg  = neg_reg ? (SUM_W'(0) - dvd_reg) : dvd_reg;
    assign diff = avg - {{(SUM_W-SAMPLE_BITS){tare_reg[SAMPLE_BITS-1]}}, tare_reg};

    assign grams = (dvd_reg > {{(SUM_W-GRAMS_W){1'b0}}, max_grams_reg}) ?
                   max_grams_reg : dvd_reg[GRAMS_W-1:0];

    always_comb begin
        ctl_next     = ctl_reg;
        dvd_next     = dvd_reg;
        dvsr_next    = dvsr_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        wtout_next   = wtout_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        unique case (ctl_reg)
            CTL_TICK: begin
                if (weigh_start) begin
                    // average: |sum| / 3, sign restored afterwards
                    neg_next   = sum_next[SUM_W-1];
                    dvd_next   = sum_next[SUM_W-1] ? (SUM_W'(0) - sum_next) : sum_next;
                    dvsr_next  = AVG_DIVISOR;
                    rem_next   = '0;
                    step_next  = '0;
                    wtout_next = tout_seen_next;
                    ctl_next   = CTL_DIV3;
                end else if (s_fire) begin
                    m_valid_next = 1'b1;
                    m_item_next  = tick_out;
                end
            end
            CTL_DIV3, CTL_DIVC: begin
                rem_next  = rem_ge ? CPG_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[CPG_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], rem_ge};
                step_next = step_reg + DIV_STEP_W'(1);
                if (step_reg == DIV_LAST) begin
                    ctl_next = (ctl_reg == CTL_DIV3) ? CTL_DIFF : CTL_DONE;
                end
            end
            CTL_DIFF: begin
                // a non-positive difference ends up as zero grams
                dvd_next  = diff[SUM_W-1] ? '0 : diff;
                dvsr_next = (cpg_reg == '0) ? CPG_W'(1) : cpg_reg;
                rem_next  = '0;
                step_next = '0;
                ctl_next  = CTL_DIVC;
            end
            CTL_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '0;
                    m_item_next.weigh_done      = 1'b1;
                    m_item_next.weight_grams    = grams;
                    m_item_next.weight_class    = classify_weight(grams);
                    m_item_next.ready_timed_out = wtout_reg;
                    ctl_next = CTL_TICK;
                end
            end
            default: begin
                ctl_next = CTL_TICK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpg_reg       <= CPG_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            max_grams_reg <= MAX_RESET;
            phase_reg     <= PH_IDLE;
            is_tare_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            rdg_cnt_reg   <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            tare_reg      <= '0;
            wait_cnt_reg  <= '0;
            tout_seen_reg <= 1'b0;
            ctl_reg       <= CTL_TICK;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_CPG:     cpg_reg       <= cfg_data[CPG_W-1:0];
                    CFG_TIMEOUT: timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                    CFG_MAX:     max_grams_reg <= cfg_data[GRAMS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_fire) begin
                phase_reg     <= phase_next;
                is_tare_reg   <= is_tare_next;
                bit_cnt_reg   <= bit_cnt_next;
                rdg_cnt_reg   <= rdg_cnt_next;
                shift_reg     <= shift_next;
                sum_reg       <= sum_next;
                tare_reg      <= tare_next;
                wait_cnt_reg  <= wait_cnt_next;
                tout_seen_reg <= tout_seen_next;
            end
            ctl_reg     <= ctl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // divider datapath and output payload
    always_ff @(posedge aclk) begin
        dvd_reg    <= dvd_next;
        dvsr_reg   <= dvsr_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
        wtout_reg  <= wtout_next;
        m_item_reg <= m_item_next;
    end

endmodule

// ----- bench/lcwc_weigh_checker.sv -----
`timescale 1ns / 1ps
// lcwc_weigh_checker: watches the item, result and register channels of the weigh unit,
// predicts every result tick and compares it. Depends on lcwc_pkg.

module lcwc_weigh_checker
    import lcwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    // register copies
    logic [CPG_W-1:0]     cpg_q;
    logic [TIMEOUT_W-1:0] tmo_q;
    logic [GRAMS_W-1:0]   max_q;

    // converter link state
    phase_t                        phase_q;
    logic                          is_tare_q;
    logic [BIT_CNT_W-1:0]          bit_cnt;
    logic [RDG_CNT_W-1:0]          rdg_cnt;
    logic [SAMPLE_BITS-1:0]        shift_q;
    logic signed [SUM_W-1:0]       sum_q;
    logic signed [SAMPLE_BITS-1:0] tare_q;
    logic [TIMEOUT_W-1:0]          wait_cnt;
    logic                          tout_q;

    out_item_t expected_ticks[$];
    out_item_t predicted;
    out_item_t want;
    int        result_no;

    function automatic logic [CLASS_W-1:0] weight_class_of(input logic [GRAMS_W-1:0] g);
        logic [CLASS_W-1:0] cls;
        if (g < G_FALSE_LIM) begin
            cls = CLS_FALSE;
        end else if (g < G_MOUSE_LO) begin
            cls = CLS_INSECT;
        end else if (g <= G_MOUSE_HI) begin
            cls = CLS_MOUSE;
        end else if (g < G_RAT_LO || g > G_RAT_HI) begin
            cls = CLS_UNKNOWN;
        end else begin
            cls = CLS_RAT;
        end
        return cls;
    endfunction

    function automatic string item_text(input out_item_t r);
        return $sformatf("clk=%0b busy=%0b wd=%0b td=%0b g=%0d cls=%0d to=%0b",
                         r.clock_pin, r.busy_res, r.weigh_done, r.tare_done,
                         r.weight_grams, r.weight_class, r.ready_timed_out);
    endfunction

    // advances the link state by one half clock period and returns that tick's result
    task automatic advance_link(input in_item_t it, output out_item_t res);
        longint               reading;
        longint               avg;
        longint               grams;
        longint               divisor;
        logic                 complete;
        logic [TIMEOUT_W-1:0] lim;
        logic [RDG_CNT_W-1:0] need;
        res = '0;
        res.busy_res = 1'b1;
        complete = 1'b0;
        reading = 0;
        case (phase_q)
            PH_IDLE: begin
                res.busy_res = 1'b0;
                if (it.command == CMD_WEIGH || it.command == CMD_TARE) begin
                    res.busy_res = 1'b1;
                    is_tare_q = (it.command == CMD_TARE);
                    rdg_cnt = '0;
                    sum_q = '0;
                    tout_q = 1'b0;
                    wait_cnt = '0;
                    phase_q = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!it.data_pin) begin
                    res.clock_pin = 1'b1;
                    bit_cnt = '0;
                    shift_q = '0;
                    phase_q = PH_SAMPLE;
                end else begin
                    // a zero limit acts as one
                    lim = (tmo_q == '0) ? TIMEOUT_W'(1) : tmo_q;
                    wait_cnt = wait_cnt + TIMEOUT_W'(1);
                    if (wait_cnt >= lim) begin
                        tout_q = 1'b1;
                        complete = 1'b1;
                    end
                end
            end
            PH_RISE: begin
                res.clock_pin = 1'b1;
                phase_q = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                shift_q = {shift_q[SAMPLE_BITS-2:0], it.data_pin};
                bit_cnt = bit_cnt + BIT_CNT_W'(1);
                phase_q = (bit_cnt >= BIT_CNT_W'(SAMPLE_BITS)) ? PH_PULSE : PH_RISE;
            end
            PH_PULSE: begin
                res.clock_pin = 1'b1;
                phase_q = PH_PULSE_END;
            end
            PH_PULSE_END: begin
                reading = longint'($signed(shift_q));
                complete = 1'b1;
            end
            default: begin
                phase_q = PH_IDLE;
                res.busy_res = 1'b0;
            end
        endcase
        if (complete) begin
            need = is_tare_q ? NEED_TARE : NEED_WEIGH;
            sum_q = sum_q + SUM_W'(reading);
            rdg_cnt = rdg_cnt + RDG_CNT_W'(1);
            wait_cnt = '0;
            if (rdg_cnt >= need) begin
                res.busy_res = 1'b0;
                res.ready_timed_out = tout_q;
                if (is_tare_q) begin
                    tare_q = SAMPLE_BITS'(reading);
                    res.tare_done = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    avg = longint'(sum_q) / AVG_COUNT;
                    divisor = (cpg_q == '0) ? 1 : longint'(cpg_q);
                    grams = (avg - longint'(tare_q)) / divisor;
                    if (grams < 0) begin
                        grams = 0;
                    end
                    if (grams > longint'(max_q)) begin
                        grams = longint'(max_q);
                    end
                    res.weight_grams = GRAMS_W'(grams);
                    res.weight_class = weight_class_of(res.weight_grams);
                    res.weigh_done = 1'b1;
                end
                phase_q = PH_IDLE;
            end else begin
                phase_q = PH_WAIT;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cpg_q <= CPG_RESET;
            tmo_q <= TIMEOUT_RESET;
            max_q <= MAX_RESET;
            phase_q = PH_IDLE;
            is_tare_q = 1'b0;
            bit_cnt = '0;
            rdg_cnt = '0;
            shift_q = '0;
            sum_q = '0;
            tare_q = '0;
            wait_cnt = '0;
            tout_q = 1'b0;
            expected_ticks.delete();
            mismatches <= 0;
            pending <= 0;
            result_no = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CPG:     cpg_q <= cfg_data[CPG_W-1:0];
                    CFG_TIMEOUT: tmo_q <= cfg_data[TIMEOUT_W-1:0];
                    CFG_MAX:     max_q <= cfg_data[GRAMS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_link(s_item, predicted);
                expected_ticks.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result %0d arrived with no item waiting for it", result_no);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_ticks.pop_front();
                    if (m_item !== want) begin
                        if (mismatches < 10) begin
                            $display("result %0d: expected %s", result_no, item_text(want));
                            $display("result %0d:      got %s", result_no, item_text(m_item));
                        end
                        mismatches <= mismatches + 1;
                    end
                end
                result_no++;
            end
            pending <= expected_ticks.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives converter ticks, register writes and result back-pressure into the
// weigh unit and gives the verdict. Depends on lcwc_pkg and lcwc_weigh_checker.

module tb_top;
    import lcwc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;

    // what the stimulus believes the block is set to
    logic [CPG_W-1:0]     cur_cpg;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [GRAMS_W-1:0]   cur_max;
    longint               tare_guess;
    int                   burst_left;
    int                   items_sent;

    load_cell_weigh_and_classify_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcwc_weigh_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [CMD_W-1:0] random_command();
        return CMD_W'($urandom_range(0, 3));
    endfunction

    // one converter tick, with bursts and gaps on the sending side
    task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic data);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid = 1'b1;
        s_item.command = cmd;
        s_item.data_pin = data;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // high ticks while waiting for data ready, then 24 bits MSB first and the extra pulse
    task automatic send_reading(input logic [SAMPLE_BITS-1:0] value, input bit timed_out);
        int lim;
        int highs;
        lim = (cur_timeout == '0) ? 1 : int'(cur_timeout);
        highs = timed_out ? lim : $urandom_range(0, (lim > 6) ? 5 : lim - 1);
        repeat (highs) send_tick(random_command(), 1'b1);
        if (!timed_out) begin
            send_tick(random_command(), 1'b0);
            for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
                send_tick(random_command(), value[b]);
                if (b != 0) begin
                    send_tick(random_command(), 1'($urandom_range(0, 1)));
                end
            end
            repeat (2) send_tick(random_command(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic take_tare(input logic [SAMPLE_BITS-1:0] value, input bit timed_out);
        send_tick(CMD_TARE, 1'($urandom_range(0, 1)));
        send_reading(value, timed_out);
        tare_guess = timed_out ? 0 : longint'($signed(value));
    endtask

    task automatic take_weight(input logic [SAMPLE_BITS-1:0] v0, input logic [SAMPLE_BITS-1:0] v1,
                               input logic [SAMPLE_BITS-1:0] v2, input logic [2:0] lost);
        send_tick(CMD_WEIGH, 1'($urandom_range(0, 1)));
        send_reading(v0, lost[0]);
        send_reading(v1, lost[1]);
        send_reading(v2, lost[2]);
    endtask

    // raw converter value: mostly aimed at a weight in grams over the current tare
    function automatic logic [SAMPLE_BITS-1:0] pick_reading(input bit for_tare);
        int     g;
        int     cpg_eff;
        longint v;
        cpg_eff = (cur_cpg == '0) ? 1 : int'(cur_cpg);
        case ($urandom_range(0, 9))
            0: return SAMPLE_BITS'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    default: return 24'hFFFFFF;
                endcase
            end
            default: ;
        endcase
        if (for_tare) begin
            return SAMPLE_BITS'(longint'($urandom_range(0, 200000)) - 100000);
        end
        case ($urandom_range(0, 2))
            0: g = $urandom_range(0, 400);
            1: begin
                case ($urandom_range(0, 10))
                    0: g = 0;    1: g = 4;    2: g = 5;    3: g = 14;
                    4: g = 15;   5: g = 30;   6: g = 31;   7: g = 149;
                    8: g = 150;  9: g = 300;  default: g = 301;
                endcase
            end
            default: g = $urandom_range(0, int'(cur_max) + 2);
        endcase
        v = tare_guess + longint'(g) * longint'(cpg_eff)
            + longint'($urandom_range(0, cpg_eff - 1));
        return SAMPLE_BITS'(v);
    endfunction

    task automatic run_sequence(input bit allow_timeout);
        bit                     tare;
        logic [SAMPLE_BITS-1:0] base;
        logic [2:0]             lost;
        tare = ($urandom_range(0, 3) == 0);
        base = pick_reading(tare);
        lost = allow_timeout ? (3'($urandom) & 3'($urandom)) : 3'b000;
        if (tare) begin
            take_tare(base, lost[0]);
        end else if ($urandom_range(0, 4) == 0) begin
            take_weight(base, pick_reading(1'b0), pick_reading(1'b0), lost);
        end else begin
            take_weight(base, base + SAMPLE_BITS'($urandom_range(0, 15)),
                        base - SAMPLE_BITS'($urandom_range(0, 15)), lost);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [CPG_W-1:0] cpg, input logic [TIMEOUT_W-1:0] tmo,
                                  input logic [GRAMS_W-1:0] mx);
        drain_results();
        write_reg(CFG_CPG, CFG_DATA_W'(cpg));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(CFG_MAX, CFG_DATA_W'(mx));
        @(negedge aclk);
        cfg_valid = 1'b0;
        cur_cpg = cpg;
        cur_timeout = tmo;
        cur_max = mx;
    endtask

    initial begin : stimulus
        logic [CPG_W-1:0]     cpg;
        logic [TIMEOUT_W-1:0] tmo;
        logic [GRAMS_W-1:0]   mx;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        items_sent = 0;
        tare_guess = 0;
        cur_cpg = CPG_RESET;
        cur_timeout = TIMEOUT_RESET;
        cur_max = MAX_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // idle ticks including the unused command code
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_SPARE, 1'b0);
        send_tick(CMD_SPARE, 1'b1);
        // reset settings: small tare, then a 20 g reading
        take_tare(24'd1000, 1'b0);
        take_weight(24'd46600, 24'd46600, 24'd46600, 3'b000);

        // zero divisor and zero timeout both act as one; timed-out tare and weigh
        apply_settings('0, '0, 16'hFFFF);
        take_tare(24'h000000, 1'b1);
        take_weight(24'h000000, 24'h000000, 24'h000000, 3'b111);
        // full-scale span saturates at the upper clamp
        take_tare(24'h800000, 1'b0);
        take_weight(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 3'b000);

        // widest divisor with a zero clamp, two readings lost to timeout
        apply_settings(16'hFFFF, 24'd3, '0);
        take_weight(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 3'b110);

        // average of -1,-1,0 truncates to zero, not to -1; the zero is a timed-out reading
        apply_settings(16'd1, 24'd2, MAX_RESET);
        take_tare(24'hFFFFFB, 1'b0);
        take_weight(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 3'b100);
        // net weight below the tare clamps at zero
        take_tare(24'h7FFFFF, 1'b0);
        take_weight(24'h800000, 24'h800000, 24'h800000, 3'b111);

        do begin
            case ($urandom_range(0, 5))
                0: cpg = 16'd1;
                1: cpg = 16'hFFFF;
                2: cpg = '0;
                3: cpg = CPG_RESET;
                default: cpg = CPG_W'($urandom_range(1, 5000));
            endcase
            case ($urandom_range(0, 5))
                0: tmo = 24'hFFFFFF;
                1: tmo = TIMEOUT_W'($urandom);
                default: tmo = TIMEOUT_W'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 4))
                0: mx = '0;
                1: mx = 16'hFFFF;
                2: mx = MAX_RESET;
                3: mx = GRAMS_W'($urandom);
                default: mx = GRAMS_W'($urandom_range(5, 400));
            endcase
            apply_settings(cpg, tmo, mx);
            repeat (2) begin
                repeat ($urandom_range(0, 3)) begin
                    send_tick(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_SPARE,
                              1'($urandom_range(0, 1)));
                end
                run_sequence(tmo <= 24'd8);
            end
        end while (items_sent < 700);

        drain_results();
        // let the divider tail and any stray output show up
        repeat (60) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("[load_cell_weigh_and_classify_unit] OK");
        end else begin
            $display("[load_cell_weigh_and_classify_unit] ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int mode;
        int stretch;
        bit held;
        held = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            // one long hold-off while items keep coming, to back the block up
            if (!held && items_sent >= 600 && s_valid) begin
                held = 1'b1;
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(4, 50);
            repeat (stretch) begin
                @(negedge aclk);
                case (mode)
                    0, 1: m_ready = 1'b1;
                    2: m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[load_cell_weigh_and_classify_unit] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lcwc_pkg.sv
hdl/load_cell_weigh_and_classify_unit.sv
bench/lcwc_weigh_checker.sv
bench/tb_top.sv
